// ----- rtl/alu64_with_status_flags_assert.svh -----
// assertion macros shared by the alu64 checker
`ifndef ALU64_WITH_STATUS_FLAGS_ASSERT_SVH
`define ALU64_WITH_STATUS_FLAGS_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define ALU64_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent a fixed number of cycles later
`define ALU64_ASSERT_LATER(label, clk, rst, ante, dly, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error(msg);

`endif

// ----- rtl/alu64_pkg.sv -----
// types and codes shared by the alu64 block
`default_nettype none
package alu64_pkg;

   localparam int WORD_WIDTH = 64;

   typedef enum logic [4:0] {
      CMD_ADD  = 5'd0,
      CMD_SUB  = 5'd1,
      CMD_MUL  = 5'd2,
      CMD_DIV  = 5'd3,
      CMD_MOD  = 5'd4,
      CMD_AND  = 5'd5,
      CMD_OR   = 5'd6,
      CMD_XOR  = 5'd7,
      CMD_SHL  = 5'd8,
      CMD_SHR  = 5'd9,
      CMD_SAR  = 5'd10,
      CMD_CMP  = 5'd11,
      CMD_TEST = 5'd12,
      CMD_INC  = 5'd13,
      CMD_DEC  = 5'd14,
      CMD_NEG  = 5'd15,
      CMD_NOT  = 5'd16
   } cmd_type;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_DIVZ  = 2'd1;
   localparam logic [1:0] ST_BADOP = 2'd2;

   typedef enum logic [1:0] {
      SEL_DIRECT = 2'd0,
      SEL_MUL    = 2'd1,
      SEL_DIV    = 2'd2,
      SEL_MOD    = 2'd3
   } sel_type;

   typedef struct packed {
      logic [4:0]            command;
      logic [WORD_WIDTH-1:0] operand_a;
      logic [WORD_WIDTH-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] result_value;
      logic                  zero_flag;
      logic                  sign_flag;
      logic                  carry_flag;
      logic                  overflow_flag;
      logic                  writes_result;
      logic                  writes_flags;
      logic [1:0]            status;
   } rsp_type;

   // control that travels down the cell chain with each request
   typedef struct packed {
      logic       valid;
      sel_type    sel;
      logic       negate;
      logic       zf;
      logic       sf;
      logic       cf;
      logic       of;
      logic       wr;
      logic       wf;
      logic [1:0] status;
   } ctrl_type;

endpackage
`default_nettype wire

// ----- rtl/alu64_decode.sv -----
// front stage: decodes the request, computes direct ops, sets up mul and div
`default_nettype none
module alu64_decode
   import alu64_pkg::*;
#(
   parameter int DATA_WIDTH = 64
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      accept,
   input  req_type                  req,
   output ctrl_type                 dec_ctrl,
   output logic [DATA_WIDTH-1:0]    dec_m,
   output logic [DATA_WIDTH-1:0]    dec_b,
   output logic [2*DATA_WIDTH-1:0]  dec_acc
);
   localparam int W = DATA_WIDTH;

   logic [W-1:0]   a, b;
   logic [5:0]     count;
   logic [W+64:0]  shl_t;
   logic [W:0]     shr_t;
   logic signed [W:0] sar_t;
   logic [W:0]     add_s, sub_d, inc_s, dec_d;

   ctrl_type       ctrl_ff, ctrl_in;
   logic [W-1:0]   m_ff, m_in, b_ff, b_in;
   logic [2*W-1:0] acc_ff, acc_in;

   assign a     = req.operand_a[W-1:0];
   assign b     = req.operand_b[W-1:0];
   assign count = req.operand_b[5:0];
   assign shl_t = {{65{1'b0}}, a} << count;
   assign shr_t = {a, 1'b0} >> count;
   assign sar_t = $signed({a, 1'b0}) >>> count;
   assign add_s = {1'b0, a} + {1'b0, b};
   assign sub_d = {1'b0, a} - {1'b0, b};
   assign inc_s = {1'b0, a} + (W+1)'(1);
   assign dec_d = {1'b0, a} - (W+1)'(1);

   always_comb begin
      logic [W-1:0] res, src, ua, ub;
      logic         cf, of, use_src, na, nb;
      ctrl_in        = '0;
      ctrl_in.valid  = accept;
      ctrl_in.sel    = SEL_DIRECT;
      ctrl_in.wr     = 1'b1;
      ctrl_in.wf     = 1'b1;
      ctrl_in.status = ST_OK;
      m_in    = a;
      b_in    = b;
      acc_in  = '0;
      res     = '0;
      src     = '0;
      cf      = 1'b0;
      of      = 1'b0;
      use_src = 1'b1;
      na      = a[W-1];
      nb      = b[W-1];
      ua      = na ? (W'(0) - a) : a;
      ub      = nb ? (W'(0) - b) : b;
      unique case (req.command) inside
         CMD_ADD: begin
            res = add_s[W-1:0];
            cf  = add_s[W];
            of  = ~(a[W-1] ^ b[W-1]) & (a[W-1] ^ res[W-1]);
            src = res;
         end
         CMD_INC: begin
            res = inc_s[W-1:0];
            cf  = inc_s[W];
            of  = ~a[W-1] & res[W-1];
            src = res;
         end
         CMD_SUB, CMD_CMP: begin
            src = sub_d[W-1:0];
            cf  = sub_d[W];
            of  = (a[W-1] ^ b[W-1]) & (a[W-1] ^ src[W-1]);
            res = (req.command == CMD_CMP) ? a : src;
            ctrl_in.wr = (req.command != CMD_CMP);
         end
         CMD_DEC: begin
            src = dec_d[W-1:0];
            cf  = dec_d[W];
            of  = a[W-1] & ~src[W-1];
            res = src;
         end
         CMD_NEG: begin
            res = W'(0) - a;
            cf  = |a;
            of  = a[W-1] & res[W-1];
            src = res;
         end
         CMD_MUL: begin
            ctrl_in.sel = SEL_MUL;
         end
         CMD_DIV, CMD_MOD: begin
            if (b == '0) begin
               ctrl_in.status = ST_DIVZ;
            end else begin
               ctrl_in.sel    = (req.command == CMD_DIV) ? SEL_DIV : SEL_MOD;
               ctrl_in.negate = (req.command == CMD_DIV) ? (na ^ nb) : na;
               m_in           = ub;
               acc_in         = {{W{1'b0}}, ua};
            end
         end
         CMD_AND: begin res = a & b; src = res; end
         CMD_OR:  begin res = a | b; src = res; end
         CMD_XOR: begin res = a ^ b; src = res; end
         CMD_TEST: begin
            res = a;
            src = a & b;
            ctrl_in.wr = 1'b0;
         end
         CMD_SHL: begin
            res = shl_t[W-1:0];
            cf  = (count != '0) & shl_t[W];
            src = res;
         end
         CMD_SHR: begin
            res = shr_t[W:1];
            cf  = (count != '0) & shr_t[0];
            src = res;
         end
         CMD_SAR: begin
            res = sar_t[W:1];
            cf  = (count != '0) & sar_t[0];
            src = res;
         end
         CMD_NOT: begin
            res        = ~a;
            use_src    = 1'b0;
            ctrl_in.wf = 1'b0;
         end
         default: begin
            ctrl_in.status = ST_BADOP;
         end
      endcase
      if (ctrl_in.status != ST_OK) begin
         res        = '0;
         cf         = 1'b0;
         of         = 1'b0;
         use_src    = 1'b0;
         ctrl_in.wr = 1'b0;
         ctrl_in.wf = 1'b0;
      end
      ctrl_in.zf = use_src & (src == '0);
      ctrl_in.sf = use_src & src[W-1];
      ctrl_in.cf = cf;
      ctrl_in.of = of;
      if (ctrl_in.sel == SEL_DIRECT) begin
         acc_in = {{W{1'b0}}, res};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_in;
      end
      m_ff   <= m_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign dec_ctrl = ctrl_ff;
   assign dec_m    = m_ff;
   assign dec_b    = b_ff;
   assign dec_acc  = acc_ff;
endmodule
`default_nettype wire

// ----- rtl/alu64_cell.sv -----
// one chain cell: one shift-add mul step, one restoring div step or pass-through
`default_nettype none
module alu64_cell
   import alu64_pkg::*;
#(
   parameter int DATA_WIDTH = 64
) (
   input  wire                      clock,
   input  wire                      reset,
   input  ctrl_type                 prev_ctrl,
   input  wire [DATA_WIDTH-1:0]     prev_m,
   input  wire [DATA_WIDTH-1:0]     prev_b,
   input  wire [2*DATA_WIDTH-1:0]   prev_acc,
   output ctrl_type                 cell_ctrl,
   output logic [DATA_WIDTH-1:0]    cell_m,
   output logic [DATA_WIDTH-1:0]    cell_b,
   output logic [2*DATA_WIDTH-1:0]  cell_acc
);
   localparam int W = DATA_WIDTH;

   ctrl_type       ctrl_ff;
   logic [W-1:0]   m_ff, b_ff, b_in;
   logic [2*W-1:0] acc_ff, acc_in;

   always_comb begin
      logic [W:0]   sum, t;
      logic [W+1:0] d;
      logic         ge;
      sum    = {1'b0, prev_acc[2*W-1:W]} + (prev_b[0] ? {1'b0, prev_m} : '0);
      t      = {prev_acc[2*W-1:W], prev_acc[W-1]};
      d      = {1'b0, t} - {2'b00, prev_m};
      ge     = ~d[W+1];
      b_in   = prev_b;
      acc_in = prev_acc;
      case (prev_ctrl.sel)
         SEL_MUL: begin
            // add under the high half, then shift the product right
            acc_in = {sum, prev_acc[W-1:1]};
            b_in   = prev_b >> 1;
         end
         SEL_DIV, SEL_MOD: begin
            // remainder in the high half, dividend shifts out as quotient shifts in
            acc_in = {(ge ? d[W-1:0] : t[W-1:0]), prev_acc[W-2:0], ge};
         end
         default: begin
            acc_in = prev_acc;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= prev_ctrl;
      end
      m_ff   <= prev_m;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign cell_ctrl = ctrl_ff;
   assign cell_m    = m_ff;
   assign cell_b    = b_ff;
   assign cell_acc  = acc_ff;
endmodule
`default_nettype wire

// ----- rtl/alu64_with_status_flags.sv -----
// top level of the alu64 block: decode stage, cell chain and result register
// Usage:
//   A request (command and two operands in req_payload) is taken at a rising
//   edge where start is high and busy is low. busy stays low, so a request may
//   be issued in every cycle.
//   Each request gives one response on rsp_payload, marked by rsp_strobe for
//   exactly one cycle; responses come out in request order.
//   Every command takes the same path: one decode stage, a chain of
//   DATA_WIDTH cells (each does one multiply step or one divide step
//   and passes the request on) and the response register.
//   Throughput is one request per cycle, set by the cell chain being fully
//   pipelined.
//   Direct (non-mul, non-div) commands ride the chain unchanged to keep order.
//   Reset (synchronous, active high) drops every request in flight; no
//   strobe follows a reset until new requests reach the end of the chain.
//   The receiver cannot stall: it must take each response when strobed.
`default_nettype none
module alu64_with_status_flags
   import alu64_pkg::*;
#(
   parameter int DATA_WIDTH = 64
) (
   input  wire      clock,
   input  wire      reset,
   input  wire      start,
   output logic     busy,
   input  req_type  req_payload,
   output logic     rsp_strobe,
   output rsp_type  rsp_payload
);
   localparam int W = DATA_WIDTH;

   ctrl_type       chain_ctrl [W+1];
   logic [W-1:0]   chain_m    [W+1];
   logic [W-1:0]   chain_b    [W+1];
   logic [2*W-1:0] chain_acc  [W+1];

   rsp_type rsp_ff, rsp_in;
   logic    strobe_ff;

   assign busy = 1'b0;

   alu64_decode #(.DATA_WIDTH(W)) u_decode (
      .clock    (clock),
      .reset    (reset),
      .accept   (start && !busy),
      .req      (req_payload),
      .dec_ctrl (chain_ctrl[0]),
      .dec_m    (chain_m[0]),
      .dec_b    (chain_b[0]),
      .dec_acc  (chain_acc[0])
   );

   for (genvar i = 0; i < W; i++) begin : g_cell
      alu64_cell #(.DATA_WIDTH(W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .prev_ctrl (chain_ctrl[i]),
         .prev_m    (chain_m[i]),
         .prev_b    (chain_b[i]),
         .prev_acc  (chain_acc[i]),
         .cell_ctrl (chain_ctrl[i+1]),
         .cell_m    (chain_m[i+1]),
         .cell_b    (chain_b[i+1]),
         .cell_acc  (chain_acc[i+1])
      );
   end

   always_comb begin
      ctrl_type     c;
      logic [W-1:0] lo, hi, r;
      c  = chain_ctrl[W];
      lo = chain_acc[W][W-1:0];
      hi = chain_acc[W][2*W-1:W];
      r  = lo;
      rsp_in               = '0;
      rsp_in.zero_flag     = c.zf;
      rsp_in.sign_flag     = c.sf;
      rsp_in.carry_flag    = c.cf;
      rsp_in.overflow_flag = c.of;
      rsp_in.writes_result = c.wr;
      rsp_in.writes_flags  = c.wf;
      rsp_in.status        = c.status;
      case (c.sel)
         SEL_MUL: begin
            r = lo;
            rsp_in.carry_flag = |hi;
         end
         SEL_DIV: begin
            r = c.negate ? (W'(0) - lo) : lo;
         end
         SEL_MOD: begin
            r = c.negate ? (W'(0) - hi) : hi;
         end
         default: begin
            r = lo;
         end
      endcase
      if (c.sel != SEL_DIRECT) begin
         rsp_in.zero_flag     = (r == '0);
         rsp_in.sign_flag     = r[W-1];
         rsp_in.overflow_flag = 1'b0;
         if (c.sel != SEL_MUL) begin
            rsp_in.carry_flag = 1'b0;
         end
      end
      rsp_in.result_value = WORD_WIDTH'(r);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= chain_ctrl[W].valid;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;
endmodule
`default_nettype wire

// ----- rtl/alu64_checker.sv -----
// port-level checks for the alu64 block, bound to the top level
`default_nettype none
`include "alu64_with_status_flags_assert.svh"
module alu64_checker
   import alu64_pkg::*;
#(
   parameter int DATA_WIDTH = 64
) (
   input wire     clock,
   input wire     reset,
   input wire     start,
   input wire     busy,
   input req_type req_payload,
   input wire     rsp_strobe,
   input rsp_type rsp_payload
);
   localparam int LAT = DATA_WIDTH + 2;

   logic err_rsp, quiet_flags, req_taken;

   assign req_taken   = start && !busy;
   assign err_rsp     = rsp_strobe && (rsp_payload.status != ST_OK);
   assign quiet_flags = rsp_strobe && (rsp_payload.status == ST_OK) && !rsp_payload.writes_flags;

   `ALU64_ASSERT_NOW(a_never_busy, clock, reset, 1'b1, !busy, "busy raised")
   `ALU64_ASSERT_LATER(a_latency, clock, reset, req_taken, LAT, rsp_strobe, "response missing")
   `ALU64_ASSERT_NOW(a_err_clean, clock, reset, err_rsp, (rsp_payload.result_value == '0) && !rsp_payload.writes_result && !rsp_payload.writes_flags && !rsp_payload.carry_flag && !rsp_payload.zero_flag, "error response not cleared")
   `ALU64_ASSERT_NOW(a_not_flags, clock, reset, quiet_flags, !rsp_payload.zero_flag && !rsp_payload.sign_flag && !rsp_payload.carry_flag && !rsp_payload.overflow_flag, "flags set without write")
endmodule

bind alu64_with_status_flags alu64_checker #(.DATA_WIDTH(DATA_WIDTH)) u_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_payload (req_payload),
   .rsp_strobe  (rsp_strobe),
   .rsp_payload (rsp_payload)
);
`default_nettype wire
